// ===== rtl/snsm_pkg.sv =====
// ----------------------------------------------------------------------------
// snsm_pkg
// Shared types, register codes and byte helpers for the short needle matcher.
// ----------------------------------------------------------------------------
package snsm_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int NEEDLE_BITS    = 64;
    localparam int LENGTH_BITS    = 4;
    localparam int OFFSET_BITS    = 32;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX   = 32'hFFFF_FFFF;
    localparam logic [BYTE_BITS-1:0]   ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_BITS-1:0]   ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_BITS-1:0]   CASE_BIT      = 8'h20;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NEEDLE_WORD   = 2'd0,
        REG_NEEDLE_LENGTH = 2'd1,
        REG_IGNORE_CASE   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [NEEDLE_BITS-1:0] needle_word;
        logic [LENGTH_BITS-1:0] needle_length;
        logic                   ignore_case;
    } cfg_t;

    // Fold ASCII A-Z to a-z when enabled
    function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] b,
                                                       input logic en);
        logic upper;
        upper = (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z);
        return (en && upper) ? (b | CASE_BIT) : b;
    endfunction

endpackage

// ===== rtl/snsm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// snsm_cfg_regs
// Configuration register file: decodes the write channel into needle settings.
// ----------------------------------------------------------------------------
module snsm_cfg_regs (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [snsm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [snsm_pkg::NEEDLE_BITS-1:0]        cfg_data,
    output snsm_pkg::cfg_t                          cfg
);

    logic [snsm_pkg::NEEDLE_BITS-1:0] needle_word_reg, needle_word_next;
    logic [snsm_pkg::LENGTH_BITS-1:0] needle_length_reg, needle_length_next;
    logic                             ignore_case_reg, ignore_case_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        needle_word_next   = needle_word_reg;
        needle_length_next = needle_length_reg;
        ignore_case_next   = ignore_case_reg;
        if (cfg_valid)
        begin
            unique case (snsm_pkg::cfg_idx_t'(cfg_index))
                snsm_pkg::REG_NEEDLE_WORD:
                    needle_word_next = cfg_data;
                snsm_pkg::REG_NEEDLE_LENGTH:
                    needle_length_next = cfg_data[snsm_pkg::LENGTH_BITS-1:0];
                snsm_pkg::REG_IGNORE_CASE:
                    ignore_case_next = cfg_data[0];
                default:
                    ; // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_word_reg   <= '0;
            needle_length_reg <= snsm_pkg::LENGTH_BITS'(1);
            ignore_case_reg   <= 1'b0;
        end
        else
        begin
            needle_word_reg   <= needle_word_next;
            needle_length_reg <= needle_length_next;
            ignore_case_reg   <= ignore_case_next;
        end
    end

    assign cfg.needle_word   = needle_word_reg;
    assign cfg.needle_length = needle_length_reg;
    assign cfg.ignore_case   = ignore_case_reg;

endmodule

// ===== rtl/snsm_match.sv =====
// ----------------------------------------------------------------------------
// snsm_match
// Byte-lane compare of the newest window bytes against the needle.
// ----------------------------------------------------------------------------
module snsm_match #(
    parameter int MAX_NEEDLE_BYTES = 8
) (
    input  logic [8*MAX_NEEDLE_BYTES-1:0]       window,
    input  logic [snsm_pkg::NEEDLE_BITS-1:0]    needle_word,
    input  logic [snsm_pkg::LENGTH_BITS-1:0]    len,
    input  logic                                ignore_case,
    output logic                                equal
);

    localparam int BB = snsm_pkg::BYTE_BITS;

    logic [MAX_NEEDLE_BYTES-1:0] lane_ok;

    // Each lane passes when it is past the needle or both folded bytes agree
    always_comb
    begin
        for (int k = 0; k < MAX_NEEDLE_BYTES; k++)
        begin
            lane_ok[k] = (snsm_pkg::LENGTH_BITS'(k) >= len) ||
                (snsm_pkg::fold_byte(window[k*BB +: BB], ignore_case) ==
                 snsm_pkg::fold_byte(needle_word[k*BB +: BB], ignore_case));
        end
    end

    assign equal = &lane_ok;

endmodule

// ===== rtl/short_needle_stream_matcher.sv =====
// ----------------------------------------------------------------------------
// short_needle_stream_matcher
// Streaming search for a 1..8 byte needle in a byte stream, one byte a cycle while results drain.
// ----------------------------------------------------------------------------
// Haystack bytes enter on the slave stream, one per word, with tlast on the
// final byte. Each haystack gives at most one result word: the start offset
// of the first match (tuser = 1), or, if the final byte arrives without a
// match, a not-found word (tuser = 0, offset 0). tlast on the result marks a
// word caused by the haystack's final byte. The block takes one byte every
// cycle while the result register is empty or draining; each byte goes
// through the input register, then the result register, with the window
// shift and the byte-lane compare between them. Configure the needle only
// while no haystack byte is in flight. Needle bytes sit in the low bytes of
// needle_word, the first needle byte in the most significant used byte.
// A length of 0 acts as 1, above MAX_NEEDLE_BYTES as MAX_NEEDLE_BYTES.
// With a one-byte needle a zero haystack byte ends the search for the rest of
// that haystack. The byte position saturates at 2^COUNT_BITS-1 and the
// reported offset at 0xFFFFFFFF.
// ----------------------------------------------------------------------------
module short_needle_stream_matcher #(
    parameter int MAX_NEEDLE_BYTES = 8,
    parameter int COUNT_BITS       = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Haystack stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
    input  logic                                s_axis_tlast,   // last_byte
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,   // [31:0] match_offset
    output logic                                m_axis_tuser,   // [0] found
    output logic                                m_axis_tlast,   // end_flag
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [snsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [snsm_pkg::NEEDLE_BITS-1:0]    cfg_data
);

    localparam int BB       = snsm_pkg::BYTE_BITS;
    localparam int WIN_BITS = BB * MAX_NEEDLE_BYTES;
    localparam int EXT_BITS = (COUNT_BITS > snsm_pkg::OFFSET_BITS) ?
                              COUNT_BITS : snsm_pkg::OFFSET_BITS;
    localparam logic [snsm_pkg::LENGTH_BITS-1:0] LEN_MAX =
                              snsm_pkg::LENGTH_BITS'(MAX_NEEDLE_BYTES);
    localparam logic [snsm_pkg::LENGTH_BITS-1:0] LEN_ONE = snsm_pkg::LENGTH_BITS'(1);

    snsm_pkg::cfg_t cfg;

    // Input stage
    logic          s1_valid_reg, s1_valid_next;
    logic [BB-1:0] s1_byte_reg;
    logic          s1_last_reg;

    // Haystack state
    logic [WIN_BITS-1:0]   window_reg, window_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  reported_reg, reported_next;
    logic                  zero_seen_reg, zero_seen_next;

    // Result stage
    logic                                  out_valid_reg, out_valid_next;
    logic [snsm_pkg::OFFSET_BITS-1:0]      out_offset_reg, out_offset_next;
    logic                                  out_found_reg, out_found_next;
    logic                                  out_last_reg, out_last_next;

    logic                                  s_fire, advance, process;
    logic [snsm_pkg::LENGTH_BITS-1:0]      len;
    logic [WIN_BITS-1:0]                   window_shift;
    logic                                  lanes_equal, hit, emit, zero_now;
    logic [COUNT_BITS-1:0]                 off_cnt;
    logic [EXT_BITS-1:0]                   off_ext;
    logic [snsm_pkg::OFFSET_BITS-1:0]      off_sat;

    snsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the result register frees the pipe when it is empty or drains
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign process       = s1_valid_reg && advance;

    // Clamp the configured length into 1..MAX_NEEDLE_BYTES
    always_comb
    begin
        priority if (cfg.needle_length == '0)
            len = LEN_ONE;
        else if (cfg.needle_length > LEN_MAX)
            len = LEN_MAX;
        else
            len = cfg.needle_length;
    end

    assign window_shift = (window_reg << BB) | WIN_BITS'(s1_byte_reg);

    snsm_match #(
        .MAX_NEEDLE_BYTES (MAX_NEEDLE_BYTES)
    ) u_match (
        .window      (window_shift),
        .needle_word (cfg.needle_word),
        .len         (len),
        .ignore_case (cfg.ignore_case),
        .equal       (lanes_equal)
    );

    // Match decision for the byte in the input stage
    always_comb
    begin
        zero_now       = zero_seen_reg || (s1_byte_reg == '0);
        zero_seen_next = zero_seen_reg;
        if (len == LEN_ONE)
        begin
            // one-byte needle: a zero byte ends the search for this haystack
            zero_seen_next = zero_now;
            hit            = !zero_now && lanes_equal;
        end
        else
        begin
            // need len bytes of this haystack before a match can count
            hit = (count_reg >= COUNT_BITS'(len - LEN_ONE)) && lanes_equal;
        end
    end

    // Start offset = old position - (len - 1); saturate into 32 bits
    assign off_cnt = count_reg - COUNT_BITS'(len - LEN_ONE);
    assign off_ext = EXT_BITS'(off_cnt);
    assign off_sat = (off_ext > EXT_BITS'(snsm_pkg::OFFSET_MAX)) ?
                     snsm_pkg::OFFSET_MAX : off_ext[snsm_pkg::OFFSET_BITS-1:0];

    assign emit = !reported_reg && (hit || s1_last_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        window_next   = window_reg;
        count_next    = count_reg;
        reported_next = reported_reg;
        if (process)
        begin
            if (s1_last_reg)
            begin
                // end of haystack: start the next one clean
                window_next   = '0;
                count_next    = '0;
                reported_next = 1'b0;
            end
            else
            begin
                window_next   = window_shift;
                count_next    = (count_reg == '1) ? count_reg : count_reg + 1'b1;
                reported_next = reported_reg || hit;
            end
        end

        out_valid_next  = out_valid_reg;
        out_offset_next = out_offset_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        if (process)
        begin
            out_valid_next  = emit;
            out_found_next  = hit;
            out_offset_next = hit ? off_sat : '0;
            out_last_next   = s1_last_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            window_reg    <= '0;
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            zero_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            zero_seen_reg <= (process && s1_last_reg) ? 1'b0 :
                             (process ? zero_seen_next : zero_seen_reg);
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
        out_offset_reg <= out_offset_next;
        out_found_reg  <= out_found_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_offset_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

    // A not-found word only comes from the last byte and carries offset 0
    a_notfound_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("not-found result without end flag or with nonzero offset");

    // A stalled input stage keeps its byte
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg)
                                     && $stable(s1_last_reg))
        else $error("input stage lost its byte while stalled");

    // A match mid-haystack blocks further results for that haystack
    a_report_once: assert property (@(posedge clk) disable iff (!rst_n)
        process && hit && !s1_last_reg |=> reported_reg)
        else $error("match not recorded as reported");

    // No result while a match of this haystack was already reported
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        process && reported_reg |=> !out_valid_reg)
        else $error("second result for one haystack");

endmodule

// ===== test/snsm_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snsm_match_checker
// Passive monitor for the short needle matcher.
// ----------------------------------------------------------------------------
// The checker follows the configuration channel and every haystack byte the
// block takes. It works out any result word a byte should produce and
// checks each result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module snsm_match_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
    input  logic                                s_axis_tlast,   // last_byte
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [31:0]                         m_axis_tdata,   // [31:0] match_offset
    input  logic                                m_axis_tuser,   // [0] found
    input  logic                                m_axis_tlast,   // end_flag
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [snsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [snsm_pkg::NEEDLE_BITS-1:0]    cfg_data,
    output int unsigned                         fail_count,
    output int unsigned                         reports_pending
);

    typedef struct {
        logic        found;
        logic [31:0] offset;
        logic        at_end;
    } search_report_t;

    search_report_t report_q[$];
    search_report_t head_rpt;

    logic [snsm_pkg::NEEDLE_BITS-1:0] needle_word_r;
    logic [snsm_pkg::LENGTH_BITS-1:0] needle_len_r;
    logic                             ignore_case_r;

    logic [63:0] byte_window;
    logic [31:0] byte_pos;
    logic        match_done;
    logic        zero_seen;
    int unsigned mismatch_count;

    function automatic logic [63:0] lower_ascii(input logic [63:0] w);
        logic [63:0] r;
        logic [7:0]  b;
        r = w;
        for (int k = 0; k < 8; k++)
        begin
            b = w[8*k +: 8];
            if (b >= snsm_pkg::ASCII_UPPER_A && b <= snsm_pkg::ASCII_UPPER_Z)
                r[8*k +: 8] = b + 8'h20;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Shift one haystack byte in and queue the result word it causes, if any.
    task automatic scan_byte(input logic [7:0] b, input logic is_last);
        int unsigned    len;
        logic [63:0]    mask;
        logic [63:0]    pat;
        logic [63:0]    win;
        logic [31:0]    pos;
        logic           hit;
        search_report_t rpt;
        pos = byte_pos;
        len = 32'(needle_len_r);
        if (len == 0)
            len = 1;
        if (len > 8)
            len = 8;
        byte_window = {byte_window[55:0], b};
        if (byte_pos != 32'hFFFF_FFFF)
            byte_pos = byte_pos + 32'd1;
        mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        pat  = needle_word_r & mask;
        win  = byte_window & mask;
        if (ignore_case_r)
        begin
            pat = lower_ascii(pat);
            win = lower_ascii(win);
        end
        if (len == 1)
        begin
            if (b == 8'h00)
                zero_seen = 1'b1;
            hit = !zero_seen && (win == pat);
        end
        else
        begin
            hit = (pos >= len - 1) && (win == pat);
        end
        if (hit && !match_done)
        begin
            rpt.found  = 1'b1;
            rpt.offset = pos + 32'd1 - len;
            rpt.at_end = is_last;
            report_q.push_back(rpt);
            match_done = 1'b1;
        end
        else if (is_last && !match_done)
        begin
            rpt.found  = 1'b0;
            rpt.offset = '0;
            rpt.at_end = 1'b1;
            report_q.push_back(rpt);
        end
        if (is_last)
        begin
            byte_window = '0;
            byte_pos    = '0;
            match_done  = 1'b0;
            zero_seen   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_word_r   = '0;
            needle_len_r    = 4'd1;
            ignore_case_r   = 1'b0;
            byte_window     = '0;
            byte_pos        = '0;
            match_done      = 1'b0;
            zero_seen       = 1'b0;
            mismatch_count  = 0;
            report_q.delete();
            fail_count      <= 0;
            reports_pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (report_q.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result word found=%0b offset=%0d end=%0b",
                                            m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    head_rpt = report_q.pop_front();
                    if (m_axis_tuser !== head_rpt.found)
                        flag_mismatch($sformatf("found got %0b want %0b",
                                                m_axis_tuser, head_rpt.found));
                    if (m_axis_tdata !== head_rpt.offset)
                        flag_mismatch($sformatf("offset got %0d want %0d",
                                                m_axis_tdata, head_rpt.offset));
                    if (m_axis_tlast !== head_rpt.at_end)
                        flag_mismatch($sformatf("end flag got %0b want %0b",
                                                m_axis_tlast, head_rpt.at_end));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    snsm_pkg::REG_NEEDLE_WORD:
                        needle_word_r = cfg_data;
                    snsm_pkg::REG_NEEDLE_LENGTH:
                        needle_len_r  = cfg_data[snsm_pkg::LENGTH_BITS-1:0];
                    snsm_pkg::REG_IGNORE_CASE:
                        ignore_case_r = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                scan_byte(s_axis_tdata, s_axis_tlast);
            fail_count      <= mismatch_count;
            reports_pending <= report_q.size();
        end
    end

endmodule

// ===== test/tb_short_needle_stream_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_short_needle_stream_matcher
// Stimulus and verdict for the short needle stream matcher.
// ----------------------------------------------------------------------------
// A short directed run covers the reset settings, case folding, short
// haystacks, repeated matches, the zero-byte stop and the length clamps.
// Random phases then change the needle, its length and case folding, and
// stream haystacks built from the needle's own bytes with planted copies,
// mixed with plain noise. Both streams stall at random. A separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_short_needle_stream_matcher;

    localparam int RANDOM_BYTES = 1600;
    localparam int LATENCY_WAIT = 8;

    logic                                clk;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [7:0]                          s_axis_tdata;   // [7:0] data_byte
    logic                                s_axis_tlast;   // last_byte
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [31:0]                         m_axis_tdata;   // [31:0] match_offset
    logic                                m_axis_tuser;   // [0] found
    logic                                m_axis_tlast;   // end_flag
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [snsm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [snsm_pkg::NEEDLE_BITS-1:0]    cfg_data;

    int unsigned fail_count;
    int unsigned reports_pending;

    // Needle as the haystack should carry it: first byte in slot 0
    logic [7:0]  needle_seq [0:7];
    int          needle_n;
    logic [7:0]  hay_buf [0:127];
    bit          tx_burst;
    int unsigned bytes_sent;

    short_needle_stream_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    snsm_match_checker match_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .reports_pending (reports_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] w;
        w = $urandom;
        return w[7:0];
    endfunction

    // Swap letter case now and then so folding gets exercised
    function automatic logic [7:0] maybe_flip(input logic [7:0] b);
        logic letter;
        letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
        if (letter && $urandom_range(0, 2) == 0)
            return b ^ 8'h20;
        return b;
    endfunction

    // Letters of either case, bytes next to the letter ranges, 00 and FF
    function automatic logic [7:0] letter_byte();
        int r;
        logic [7:0] edges [0:3];
        edges[0] = 8'h40;
        edges[1] = 8'h5B;
        edges[2] = 8'h60;
        edges[3] = 8'h7B;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'h00;
        else if (r < 16)
            return 8'hFF;
        else if (r < 26)
            return edges[$urandom_range(0, 3)];
        else if (r < 90)
            return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
        else
            return rand_byte();
    endfunction

    // Bias haystack content toward the needle's own bytes to get near misses
    function automatic logic [7:0] haystack_byte();
        if ($urandom_range(0, 99) < 45)
            return maybe_flip(needle_seq[$urandom_range(0, needle_n - 1)]);
        return letter_byte();
    endfunction

    // Present one word on the haystack stream and hold it until it is taken
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = tx_burst ? 0 : idle_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit close_it);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close_it && (i == s.len() - 1));
    endtask

    // Drop valid, wait for every predicted word, then let the pipeline settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0) @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // Write all three registers back to back; valid stays high between them
    task automatic write_config(input logic [63:0] word, input logic [63:0] len_val,
                                input logic [63:0] ic_val);
        int n;
        cfg_valid <= 1'b1;
        cfg_index <= snsm_pkg::REG_NEEDLE_WORD;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= snsm_pkg::REG_NEEDLE_LENGTH;
        cfg_data  <= len_val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= snsm_pkg::REG_IGNORE_CASE;
        cfg_data  <= ic_val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        // Keep the stream-order needle for planting copies in haystacks
        n = int'(len_val[3:0]);
        if (n == 0)
            n = 1;
        if (n > 8)
            n = 8;
        needle_n = n;
        for (int i = 0; i < n; i++)
            needle_seq[i] = word[8*(n-1-i) +: 8];
    endtask

    task automatic pick_config(input int phase);
        logic [63:0] word;
        logic [63:0] len_val;
        logic [63:0] ic_val;
        int          len;
        unique case (phase % 8)
            0:       len = 1;
            1:       len = 8;
            2:       len = 0;
            3:       len = $urandom_range(9, 15);
            default: len = $urandom_range(1, 8);
        endcase
        for (int i = 0; i < 8; i++)
            word[8*i +: 8] = letter_byte();
        if (phase % 11 == 5)
            word = '0;
        else if (phase % 13 == 6)
            word = '1;
        // Upper bits of the narrow registers must be ignored
        len_val      = {$urandom, $urandom};
        len_val[3:0] = 4'(len);
        ic_val       = {$urandom, $urandom};
        write_config(word, len_val, ic_val);
    endtask

    // Build one haystack, plant the needle in some of them, and stream it;
    // leave the haystack open when close_it is clear
    task automatic send_haystack(input bit close_it);
        int len;
        int at;
        bit noise;
        tx_burst = ($urandom_range(0, 3) == 0);
        noise    = ($urandom_range(0, 4) == 0);
        len      = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
        for (int i = 0; i < len; i++)
            hay_buf[i] = noise ? rand_byte() : haystack_byte();
        if (!noise && $urandom_range(0, 9) < 6 && len >= needle_n)
        begin
            at = $urandom_range(0, len - needle_n);
            for (int i = 0; i < needle_n; i++)
                hay_buf[at + i] = maybe_flip(needle_seq[i]);
        end
        for (int i = 0; i < len; i++)
            send_byte(hay_buf[i], close_it && (i == len - 1));
    endtask

    // Result side: ready in runs, mostly short stalls, some long ready stretches
    initial
    begin : result_stall
        int run_len;
        int stall_len;
        m_axis_tready = 1'b0;
        forever
        begin
            run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                    : $urandom_range(1, 12);
            stall_len = idle_gap();
            if (stall_len == 0)
                stall_len = 1;
            @(posedge clk);
            m_axis_tready <= 1'b1;
            repeat (run_len - 1) @(posedge clk);
            @(posedge clk);
            m_axis_tready <= 1'b0;
            repeat (stall_len - 1) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int phase;
        int nhay;
        int target;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = snsm_pkg::REG_NEEDLE_WORD;
        cfg_data      = '0;
        tx_burst      = 1'b0;
        bytes_sent    = 0;
        needle_n      = 1;
        for (int i = 0; i < 8; i++)
            needle_seq[i] = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero one-byte needle, a zero byte never matches
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);

        // Folded three-byte needle with junk in the unused needle bytes:
        // a match on the final byte, a haystack too short, a repeated match
        drain_results();
        write_config(64'hDEAD_BEEF_CA61_6263, 64'd3, 64'd1);
        send_text("xABC", 1'b1);
        send_text("ab", 1'b1);
        send_text("abCabc", 1'b1);

        // Length zero acts as one; match ahead of the final byte
        drain_results();
        write_config(64'h0000_0000_0000_00FF, 64'd0, 64'd0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);

        // Length above eight clamps to eight
        drain_results();
        write_config('1, 64'd15, 64'd0);
        for (int i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);

        // Random phases; a phase may end inside a haystack so the next
        // settings apply to the rest of it
        target = bytes_sent + RANDOM_BYTES;
        phase  = 0;
        while (bytes_sent < target)
        begin
            drain_results();
            pick_config(phase);
            nhay = $urandom_range(3, 10);
            for (int h = 0; h < nhay; h++)
                send_haystack(!(h == nhay - 1 && $urandom_range(0, 4) == 0));
            phase++;
        end

        drain_results();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
